FILE: design/assert_macros.svh
// Assertion macros shared by the timer slot pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define TSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication in the cycle after its antecedent.
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/tsp_pkg.sv
// Package of types and constants for the timer slot pool.
`timescale 1ns / 1ps
package tsp_pkg;
  localparam int unsigned Slots = 64;
  localparam int unsigned SlotBits = $clog2(Slots);
  localparam int unsigned CountBits = $clog2(Slots + 1);
  localparam int unsigned TimeBits = 48;
  localparam int unsigned TagBits = 32;
  localparam int unsigned PeriodBits = 32;
  localparam int unsigned EntryBits = TimeBits + PeriodBits + TagBits;

  localparam logic [1:0] CmdSched  = 2'd0;
  localparam logic [1:0] CmdCancel = 2'd1;
  localparam logic [1:0] CmdFire   = 2'd2;
  localparam logic [1:0] CmdCheck  = 2'd3;

  localparam logic [2:0] KindSched    = 3'd0;
  localparam logic [2:0] KindFull     = 3'd1;
  localparam logic [2:0] KindCancel   = 3'd2;
  localparam logic [2:0] KindInactive = 3'd3;
  localparam logic [2:0] KindFired    = 3'd4;

  // Commands from controller to datapath.
  typedef struct packed {
    logic                load;      // capture input beat
    logic                rd_en;     // read entry at rd_addr
    logic [SlotBits-1:0] rd_addr;
    logic                do_write;  // write new schedule entry at free slot
    logic                do_adv;    // advance ring time of read entry
    logic                set_act;   // mark slot active
    logic                clr_act;   // mark slot free
    logic [SlotBits-1:0] act_addr;
  } tsp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic                has_free;
    logic [SlotBits-1:0] free_slot;
    logic                expired;   // read entry is due
    logic                one_shot;  // read entry has no period
  } tsp_sts_t;
endpackage

FILE: design/tsp_ram.sv
// Generic RAM with one write port, one read port and registered read.
`timescale 1ns / 1ps
module tsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/tsp_datapath.sv
// Datapath: slot store, active flags, free-slot search and due test.
`timescale 1ns / 1ps
module tsp_datapath import tsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsp_cmd_t              cmd_i,
  input  logic [PeriodBits-1:0] delay_ms_i,
  input  logic                  repeat_req_i,
  input  logic [TagBits-1:0]    target_tag_i,
  input  logic [TimeBits-1:0]   now_ms_i,
  input  logic [SlotBits-1:0]   slot_i,
  output tsp_sts_t              sts_o,
  output logic [Slots-1:0]      active_o,
  output logic [TagBits-1:0]    rd_tag_o
);
  logic [Slots-1:0]      act_q;
  logic [PeriodBits-1:0] dly_q;
  logic                  rep_q;
  logic [TagBits-1:0]    tag_q;
  logic [TimeBits-1:0]   now_q;
  logic [SlotBits-1:0]   raddr_q;
  logic [EntryBits-1:0]  rdata;
  logic [EntryBits-1:0]  wdata;
  logic [SlotBits-1:0]   waddr;
  logic                  we;
  logic [TimeBits-1:0]   rd_ring;
  logic [PeriodBits-1:0] rd_per;
  logic [PeriodBits-1:0] dly_eff;

  // Capture the beat; note the read address for write-back.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dly_q <= delay_ms_i;
      rep_q <= repeat_req_i;
      tag_q <= target_tag_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.rd_en) raddr_q <= cmd_i.rd_addr;
  end

  // Hold the active flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else if (cmd_i.set_act) begin
      act_q[cmd_i.act_addr] <= 1'b1;
    end else if (cmd_i.clr_act) begin
      act_q[cmd_i.act_addr] <= 1'b0;
    end
  end

  // Find the lowest free slot.
  always_comb begin
    sts_o.has_free  = 1'b0;
    sts_o.free_slot = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        sts_o.has_free  = 1'b1;
        sts_o.free_slot = SlotBits'(i);
      end
    end
  end

  assign rd_ring  = rdata[EntryBits-1 -: TimeBits];
  assign rd_per   = rdata[TagBits +: PeriodBits];
  assign rd_tag_o = rdata[TagBits-1:0];
  assign dly_eff  = (dly_q == '0) ? PeriodBits'(1) : dly_q;
  assign sts_o.expired  = (rd_ring <= now_q);
  assign sts_o.one_shot = (rd_per == '0);
  assign active_o = act_q;

  // Select the entry to write: a new schedule or an advanced ring time.
  always_comb begin
    we    = cmd_i.do_write | cmd_i.do_adv;
    waddr = cmd_i.do_write ? sts_o.free_slot : raddr_q;
    if (cmd_i.do_write) begin
      wdata = {now_q + TimeBits'(dly_eff), (rep_q ? dly_eff : '0), tag_q};
    end else begin
      wdata = {rd_ring + TimeBits'(rd_per), rd_per, rd_tag_o};
    end
  end

  tsp_ram #(.Width(EntryBits), .Depth(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_en ? cmd_i.rd_addr : slot_i),
    .rdata_o (rdata)
  );
endmodule

FILE: design/tsp_ctrl.sv
// Controller: command sequencing, slot scan and result register.
`timescale 1ns / 1ps
module tsp_ctrl import tsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [SlotBits-1:0]  slot_i,
  input  logic                 has_old_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           kind_o,
  output logic [SlotBits-1:0]  out_slot_o,
  output logic [TagBits-1:0]   out_tag_o,
  output logic [CountBits-1:0] active_total_o,
  output logic                 last_o,
  output tsp_cmd_t             dp_o,
  input  tsp_sts_t             sts_i,
  input  logic [Slots-1:0]     active_i,
  input  logic [TagBits-1:0]   rd_tag_i
);
  typedef enum logic [2:0] {
    StIdle, StSched, StFire, StScan, StTest, StLast
  } state_e;

  state_e               state_q, state_d;
  logic [SlotBits-1:0]  slot_q, slot_d;
  logic [SlotBits:0]    idx_q, idx_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 vld_q, vld_d;
  logic [2:0]           kind_q, kind_d;
  logic [SlotBits-1:0]  oslot_q, oslot_d;
  logic [TagBits-1:0]   otag_q, otag_d;
  logic [CountBits-1:0] otot_q, otot_d;
  logic                 last_q, last_d;
  logic                 pend_q, pend_d;
  logic [SlotBits-1:0]  pslot_q, pslot_d;
  logic [TagBits-1:0]   ptag_q, ptag_d;
  logic [CountBits-1:0] ptot_q, ptot_d;
  logic                 old_ok;

  assign old_ok = active_i[slot_i];
  assign in_stall_o = (state_q != StIdle) | vld_q;
  assign out_valid_o = vld_q;
  assign kind_o = kind_q;
  assign out_slot_o = oslot_q;
  assign out_tag_o = otag_q;
  assign active_total_o = otot_q;
  assign last_o = last_q;

  // Next state, datapath commands and the result beat.
  always_comb begin
    state_d = state_q; slot_d = slot_q; idx_d = idx_q;
    cnt_d = cnt_q; vld_d = vld_q; kind_d = kind_q; oslot_d = oslot_q;
    otag_d = otag_q; otot_d = otot_q; last_d = last_q;
    pend_d = pend_q; pslot_d = pslot_q; ptag_d = ptag_q; ptot_d = ptot_q;
    dp_o = '0;
    if (vld_q && !out_stall_i) vld_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && !vld_q) begin
          dp_o.load = 1'b1;
          slot_d = slot_i; otag_d = '0; last_d = 1'b1;
          oslot_d = slot_i;
          case (cmd_i)
            CmdSched: begin
              if (cnt_q == CountBits'(Slots)) begin
                kind_d = KindFull; oslot_d = '0; vld_d = 1'b1;
              end else begin
                if (has_old_i && old_ok) begin
                  dp_o.clr_act = 1'b1; dp_o.act_addr = slot_i;
                  cnt_d = cnt_q - 1'b1;
                end
                state_d = StSched;
              end
            end
            CmdCancel: begin
              if (old_ok) begin
                dp_o.clr_act = 1'b1; dp_o.act_addr = slot_i;
                cnt_d = cnt_q - 1'b1; kind_d = KindCancel;
              end else begin
                kind_d = KindInactive;
              end
              vld_d = 1'b1;
            end
            CmdFire: begin
              if (old_ok) begin
                dp_o.rd_en = 1'b1; dp_o.rd_addr = slot_i;
                state_d = StFire;
              end else begin
                kind_d = KindInactive; vld_d = 1'b1;
              end
            end
            CmdCheck: begin
              idx_d = '0; pend_d = 1'b0; state_d = StScan;
            end
            default: ;
          endcase
          otot_d = cnt_d;
        end
      end
      StSched: begin
        dp_o.do_write = 1'b1; dp_o.set_act = 1'b1;
        dp_o.act_addr = sts_i.free_slot;
        cnt_d = cnt_q + 1'b1; otot_d = cnt_q + 1'b1;
        kind_d = KindSched; oslot_d = sts_i.free_slot;
        vld_d = 1'b1; state_d = StIdle;
      end
      StFire: begin
        dp_o.clr_act = 1'b1; dp_o.act_addr = slot_q;
        cnt_d = cnt_q - 1'b1; otot_d = cnt_q - 1'b1;
        kind_d = KindFired; otag_d = rd_tag_i;
        vld_d = 1'b1; state_d = StIdle;
      end
      StScan: begin
        // Read the next active slot, or finish the check.
        if (idx_q == (SlotBits + 1)'(Slots)) begin
          state_d = pend_q ? StLast : StIdle;
        end else if (active_i[idx_q[SlotBits-1:0]]) begin
          dp_o.rd_en = 1'b1; dp_o.rd_addr = idx_q[SlotBits-1:0];
          state_d = StTest;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StTest: begin
        // Hold a due slot until the held-back beat can move out.
        if (!sts_i.expired) begin
          idx_d = idx_q + 1'b1; state_d = StScan;
        end else if (!pend_q || !vld_d) begin
          if (pend_q) begin
            kind_d = KindFired; oslot_d = pslot_q; otag_d = ptag_q;
            otot_d = ptot_q; last_d = 1'b0; vld_d = 1'b1;
          end
          if (sts_i.one_shot) begin
            dp_o.clr_act = 1'b1; dp_o.act_addr = idx_q[SlotBits-1:0];
            cnt_d = cnt_q - 1'b1;
          end else begin
            dp_o.do_adv = 1'b1;
          end
          pend_d = 1'b1; pslot_d = idx_q[SlotBits-1:0];
          ptag_d = rd_tag_i; ptot_d = cnt_d;
          idx_d = idx_q + 1'b1; state_d = StScan;
        end
      end
      StLast: begin
        // Release the held-back beat as the final one.
        if (!vld_d) begin
          kind_d = KindFired; oslot_d = pslot_q; otag_d = ptag_q;
          otot_d = ptot_q; last_d = 1'b1; vld_d = 1'b1;
          pend_d = 1'b0; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; slot_q <= '0; idx_q <= '0;
      cnt_q <= '0; vld_q <= 1'b0; kind_q <= KindSched; oslot_q <= '0;
      otag_q <= '0; otot_q <= '0; last_q <= 1'b0;
      pend_q <= 1'b0; pslot_q <= '0; ptag_q <= '0; ptot_q <= '0;
    end else begin
      state_q <= state_d; slot_q <= slot_d; idx_q <= idx_d;
      cnt_q <= cnt_d; vld_q <= vld_d; kind_q <= kind_d; oslot_q <= oslot_d;
      otag_q <= otag_d; otot_q <= otot_d; last_q <= last_d;
      pend_q <= pend_d; pslot_q <= pslot_d; ptag_q <= ptag_d; ptot_q <= ptot_d;
    end
  end
endmodule

FILE: design/timer_slot_pool.sv
// Top level of the timer slot pool.
`timescale 1ns / 1ps
// Pool of 64 timer slots. One input beat carries a command: schedule,
// cancel, fire now, or check expiries. Each beat gives result beats on
// the output channel; last marks the final one. A check with nothing
// due gives no result beat.
// Both channels use valid/stall. The input is stalled while a command
// runs or a result beat waits, so one item is handled at a time.
// Steps: cancel answers from idle; fire now reads the store, then
// gives its beat; schedule does the free-slot search and the store
// write. A check walks the slots in turn, with a store read and then
// a due test for each active slot; it then ends the walk and, if a
// slot was due, releases the final beat.
// A fired beat is held back until the next due slot is found or the
// scan ends, so last is known.
// Reset clears all active flags and the count at once; stored entries
// of free slots are never read, so no clearing pass is needed.
// While the receiver stalls, the result beat holds and the scan waits
// at the next due slot.
module timer_slot_pool import tsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [SlotBits-1:0]  slot_i,
  input  logic                 has_old_i,
  input  logic [31:0]          delay_ms_i,
  input  logic                 repeat_req_i,
  input  logic [TagBits-1:0]   target_tag_i,
  input  logic [TimeBits-1:0]  now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           kind_o,
  output logic [SlotBits-1:0]  out_slot_o,
  output logic [TagBits-1:0]   out_tag_o,
  output logic [CountBits-1:0] active_total_o,
  output logic                 last_o
);
`include "assert_macros.svh"
  tsp_cmd_t         dp_cmd;
  tsp_sts_t         dp_sts;
  logic [Slots-1:0] active;
  logic [TagBits-1:0] rd_tag;

  tsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .slot_i, .has_old_i,
    .out_valid_o, .out_stall_i, .kind_o, .out_slot_o, .out_tag_o,
    .active_total_o, .last_o,
    .dp_o(dp_cmd), .sts_i(dp_sts), .active_i(active), .rd_tag_i(rd_tag)
  );

  tsp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .delay_ms_i, .repeat_req_i,
    .target_tag_i, .now_ms_i, .slot_i, .sts_o(dp_sts), .active_o(active),
    .rd_tag_o(rd_tag)
  );

  `TSP_ASSERT_IMP(a_total_range, clk_i, rst_ni, out_valid_o,
    active_total_o <= CountBits'(Slots), "active total out of range")
  `TSP_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, out_valid_o,
    in_stall_o, "input accepted while result pending")
  `TSP_ASSERT_NEXT(a_sched_sets, clk_i, rst_ni, dp_cmd.set_act,
    active_total_o != '0, "schedule left pool empty")
endmodule
